>>> hw/rtl/mnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_pkg: shared definitions for the mutual neighbor pair finder
// field widths, request kinds, stream packing and the compare result type
// ----------------------------------------------------------------------------
package mnp_pkg;

    localparam int FIELD_W = 10;
    localparam int K_REG_W = 6;
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    localparam logic [K_REG_W-1:0] K_RESET = 6'd32;

    // request kinds carried on the input tuser
    localparam logic [TUSER_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [TUSER_W-1:0] OP_QUERY = 2'd1;
    localparam logic [TUSER_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic lt;   // a below b
        logic eq;   // a equal to b
    } cmp_t;

endpackage

>>> hw/rtl/mnp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mnp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/mnp_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_cmp: shared index comparator
// gives less-than and equal for the insertion shift and the lower bound search
// ----------------------------------------------------------------------------
module mnp_cmp (
    input  logic [mnp_pkg::FIELD_W-1:0] a,
    input  logic [mnp_pkg::FIELD_W-1:0] b,
    output mnp_pkg::cmp_t               res
);

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

>>> hw/rtl/mutual_neighbor_pair_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutual_neighbor_pair_finder_unit: mutual nearest neighbor pair finder
// keeps sorted neighbor rows per right observation and matches left queries
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: tuser is the kind (load, query, clear),
//   tdata holds observation and neighbor. m_axis carries a found pair.
//   cfg_valid/cfg_data writes the neighbor count K; cfg_ready is always high,
//   write it only while the block is idle.
// steps (one request at a time, s_axis_tready is low while one is worked on)
//   load : the row's fill is read and the new entry counted, then larger
//          entries move up one place until it fits; full rows are left as is
//   query: a lower bound search starts at the row's resume offset; each
//          search step is a read of the row ram and a pass through the shared
//          comparator, one more read checks equality and a match loads the
//          output register; a query on an exhausted row ends after the row read
//   clear: every row of fill/offset state is zeroed, one row per cycle
//   unknown kinds and out-of-range rows are taken with no effect
// reset
//   after rst_n rises the block sweeps every row of the fill/offset ram
//   before it raises s_axis_tready; the sorted row ram is never cleared
// stall
//   a found pair sits in the output register until m_axis_tready; new requests
//   are still taken, and a later pair waits in its last step until it is free
// ----------------------------------------------------------------------------
module mutual_neighbor_pair_finder_unit #(
    parameter int MAX_OBS = 1024,
    parameter int MAX_K   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tdata: observation [9:0], neighbor [19:10], zero [23:20]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mnp_pkg::TDATA_W-1:0]   s_axis_tdata,
    // tuser: op [1:0]
    input  logic [mnp_pkg::TUSER_W-1:0]   s_axis_tuser,
    // tdata: left_observation [9:0], right_observation [19:10], zero [23:20]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mnp_pkg::TDATA_W-1:0]   m_axis_tdata,
    // neighbors_in_use
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mnp_pkg::K_REG_W-1:0]   cfg_data
);

    localparam int FW   = mnp_pkg::FIELD_W;
    localparam int RW   = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
    localparam int KW   = $clog2(MAX_K + 1);
    localparam int EW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int DAW  = RW + EW;
    localparam int PADW = mnp_pkg::TDATA_W - 2 * FW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_SHIFT,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_FIND,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [mnp_pkg::TUSER_W-1:0]   op_reg, op_next;
    logic [FW-1:0]                 obs_reg, obs_next;
    logic [FW-1:0]                 nb_reg, nb_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [RW-1:0]                 clr_reg, clr_next;
    logic [KW-1:0]                 fill_reg, fill_next;
    logic [KW-1:0]                 pos_reg, pos_next;
    logic [KW-1:0]                 lo_reg, lo_next;
    logic [KW-1:0]                 hi_reg, hi_next;
    logic [KW-1:0]                 mid_reg, mid_next;
    logic [KW-1:0]                 end_reg, end_next;
    logic [mnp_pkg::K_REG_W-1:0]   k_reg, k_next;
    logic                          out_valid_reg, out_valid_next;
    logic [FW-1:0]                 out_left_reg, out_left_next;
    logic [FW-1:0]                 out_right_reg, out_right_next;

    // fill/offset ram: {fill, offset} per row
    logic                          st_we;
    logic [RW-1:0]                 st_waddr, st_raddr;
    logic [2*KW-1:0]               st_wdata, st_rdata;
    // sorted row ram: {row, entry}
    logic                          dt_we;
    logic [DAW-1:0]                dt_waddr, dt_raddr;
    logic [FW-1:0]                 dt_wdata, dt_rdata;

    logic [FW-1:0]                 cmp_a, cmp_b;
    mnp_pkg::cmp_t                 cmp_res;

    logic [FW-1:0]                 in_obs, in_nb;
    logic                          in_fire;
    logic [KW-1:0]                 eff_k;
    logic [KW-1:0]                 rd_fill, rd_off;
    logic [KW-1:0]                 fill_m1, pos_m1, pos_m2, row_end, lo_start;
    logic [KW-1:0]                 mid_calc;

    assign in_obs  = s_axis_tdata[FW-1:0];
    assign in_nb   = s_axis_tdata[2*FW-1:FW];
    assign in_fire = s_axis_tvalid & s_axis_tready;

    // K saturates at the row capacity
    assign eff_k = (32'(k_reg) > MAX_K) ? KW'(MAX_K) : KW'(k_reg);

    assign rd_fill  = st_rdata[2*KW-1:KW];
    assign rd_off   = st_rdata[KW-1:0];
    assign fill_m1  = rd_fill - KW'(1);
    assign pos_m1   = pos_reg - KW'(1);
    assign pos_m2   = pos_reg - KW'(2);
    assign row_end  = (rd_fill < eff_k) ? rd_fill : eff_k;
    assign lo_start = (rd_off > row_end) ? row_end : rd_off;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PADW{1'b0}}, out_right_reg, out_left_reg};

    mnp_ram #(
        .WIDTH (2 * KW),
        .DEPTH (MAX_OBS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    mnp_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_OBS * (2 ** EW))
    ) u_row_ram (
        .clk   (clk),
        .we    (dt_we),
        .waddr (dt_waddr),
        .wdata (dt_wdata),
        .raddr (dt_raddr),
        .rdata (dt_rdata)
    );

    mnp_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        obs_next       = obs_reg;
        nb_next        = nb_reg;
        row_next       = row_reg;
        clr_next       = clr_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        end_next       = end_reg;
        k_next         = cfg_valid ? cfg_data : k_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;

        st_we    = 1'b0;
        st_waddr = row_reg;
        st_wdata = {fill_reg, lo_reg};
        st_raddr = row_reg;
        dt_we    = 1'b0;
        dt_waddr = {row_reg, pos_reg[EW-1:0]};
        dt_wdata = nb_reg;
        dt_raddr = {row_reg, lo_reg[EW-1:0]};
        cmp_a    = dt_rdata;
        cmp_b    = obs_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero fill and offset, one row per cycle
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = clr_reg + RW'(1);
                if (clr_reg == RW'(MAX_OBS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = s_axis_tuser;
                    obs_next = in_obs;
                    nb_next  = in_nb;
                    unique case (s_axis_tuser)
                        mnp_pkg::OP_LOAD:
                        begin
                            if (32'(in_obs) < MAX_OBS)
                            begin
                                row_next   = RW'(in_obs);
                                st_raddr   = RW'(in_obs);
                                state_next = ST_ROW;
                            end
                        end
                        mnp_pkg::OP_QUERY:
                        begin
                            if (32'(in_nb) < MAX_OBS)
                            begin
                                row_next   = RW'(in_nb);
                                st_raddr   = RW'(in_nb);
                                state_next = ST_ROW;
                            end
                        end
                        mnp_pkg::OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                fill_next = rd_fill;
                if (op_reg == mnp_pkg::OP_LOAD)
                begin
                    if (rd_fill >= eff_k)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // count the new entry now, then shift it into place
                        st_we      = 1'b1;
                        st_wdata   = {rd_fill + KW'(1), rd_off};
                        pos_next   = rd_fill;
                        dt_raddr   = {row_reg, fill_m1[EW-1:0]};
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    if (rd_off >= eff_k)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        end_next   = row_end;
                        lo_next    = lo_start;
                        hi_next    = row_end;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SHIFT:
            begin
                // dt_rdata holds the entry just below pos
                cmp_a = nb_reg;
                cmp_b = dt_rdata;
                dt_we = 1'b1;
                if ((pos_reg != '0) && cmp_res.lt)
                begin
                    dt_wdata = dt_rdata;
                    pos_next = pos_m1;
                    dt_raddr = {row_reg, pos_m2[EW-1:0]};
                end
                else
                begin
                    dt_wdata   = nb_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    dt_raddr   = {row_reg, mid_calc[EW-1:0]};
                    state_next = ST_SRCH_CMP;
                end
                else if (lo_reg < end_reg)
                begin
                    dt_raddr   = {row_reg, lo_reg[EW-1:0]};
                    state_next = ST_FIND;
                end
                else
                begin
                    st_we      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_CMP:
            begin
                if (cmp_res.lt)
                begin
                    lo_next = mid_reg + KW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH;
            end
            ST_FIND:
            begin
                // resume offset moves to the lower bound either way
                st_we      = 1'b1;
                state_next = cmp_res.eq ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_left_next  = obs_reg;
                    out_right_next = nb_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= '0;
            obs_reg       <= '0;
            nb_reg        <= '0;
            row_reg       <= '0;
            clr_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            end_reg       <= '0;
            k_reg         <= mnp_pkg::K_RESET;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            obs_reg       <= obs_next;
            nb_reg        <= nb_next;
            row_reg       <= row_next;
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            end_reg       <= end_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
        end
    end

endmodule

>>> hw/rtl/mnp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_checker: port-level checks for the mutual neighbor pair finder
// watches the stream channels over time, attached to the top level by bind
// ----------------------------------------------------------------------------
module mnp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [mnp_pkg::TUSER_W-1:0] s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [mnp_pkg::TDATA_W-1:0] m_axis_tdata
);

    // a pending pair stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a pending pair keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a clear request starts the sweep, so the input closes
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mnp_pkg::OP_CLEAR)
        |=> !s_axis_tready)
        else $error("input open right after clear request");

    // a load request never produces a pair
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mnp_pkg::OP_LOAD)
        |=> !$rose(m_axis_tvalid))
        else $error("pair raised after load request");

endmodule

bind mutual_neighbor_pair_finder_unit mnp_checker u_mnp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
